/* hw/rtl/length_prefixed_packet_ring_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the packet ring
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_RING_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_RING_DEFINES_SVH

`ifndef SYNTHESIS
`define LPPR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define LPPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPPR_ASSERT(lbl, clk, rstn, prop, msg)
`define LPPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hw/rtl/lppr_pkg.sv */
// ----------------------------------------------------------------------------
// lppr_pkg
// Sizes, codes and index arithmetic shared by the packet ring.
// ----------------------------------------------------------------------------
package lppr_pkg;

  localparam int RING_BYTES   = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int IDX_W        = $clog2(RING_BYTES);
  localparam int CNT_W        = $clog2(RING_BYTES + 1);
  localparam int CMP_W        = 17;
  localparam int HK_W         = $clog2(HEADER_BYTES);

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_WR_BEGIN = 3'd1,
    OP_WR_BYTE  = 3'd2,
    OP_RD_BEGIN = 3'd3,
    OP_RD_BYTE  = 3'd4,
    OP_RETAIN   = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_SEQ       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_WHDR,
    SQ_HDR_LO,
    SQ_HDR_HI
  } seq_e;

  // advance a ring index by n, with n at most RING_BYTES
  function automatic logic [IDX_W-1:0] adv(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(idx) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(RING_BYTES)) begin
      s = s - (CNT_W+1)'(RING_BYTES);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

/* hw/rtl/lppr_ram.sv */
// ----------------------------------------------------------------------------
// lppr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lppr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/length_prefixed_packet_ring.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring
// Byte ring holding whole packets, each behind a 4-byte little-endian length.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result beat. clear, write_byte,
// read_byte and every out-of-sequence, no_space, empty or ignored item are
// handled straight from idle, so payload bytes stream at one per cycle while
// result beats are accepted. An accepted write_begin writes its four header
// bytes one at a time through the single RAM write port. read_begin on a
// non-empty ring reads two header bytes through the registered RAM read
// port, also when it reports too_small; retain reads two bytes per header
// it walks. The next payload byte of a packet being read is prefetched from
// the RAM. The result sits in an output register; a new item is taken only
// while that register is empty or in the cycle its beat is accepted. The
// store has no reset; only committed packets are read back.
`include "length_prefixed_packet_ring_defines.svh"

module length_prefixed_packet_ring
  import lppr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] length_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [16:0] result_length_o,
  output logic [7:0]  read_byte_o,
  output logic        last_byte_o,
  output logic [10:0] free_bytes_o
);

  seq_e             sq_q, sq_d;
  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d, cursor_q, cursor_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [15:0]      left_q, left_d, pkt_q, pkt_d, len_q, len_d;
  logic [7:0]       lo_q, lo_d;
  opcode_e          op_q, op_d;
  logic [HK_W-1:0]  hk_q, hk_d;

  logic             out_valid_q, out_valid_d, out_load;
  status_e          o_status, status_q;
  logic [16:0]      o_rlen, rlen_q;
  logic [7:0]       o_rbyte, rbyte_q;
  logic             o_last, last_q;
  logic [CNT_W-1:0] free_q, free_d, free_now;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr, hdr_addr;
  logic [7:0]       wdata, rdata;
  logic             hdr_rd;
  logic             in_fire;
  opcode_e          op;
  logic [CMP_W-1:0] need, pk_total;
  logic [15:0]      pk;

  lppr_ram #(
    .DEPTH(RING_BYTES),
    .WIDTH(8)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_ready_o = (sq_q == SQ_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = opcode_e'(opcode_i);
  assign free_now   = CNT_W'(RING_BYTES) - used_q;
  assign need       = CMP_W'(length_i) + CMP_W'(HEADER_BYTES);
  assign pk         = {rdata, lo_q};
  assign pk_total   = CMP_W'(pk) + CMP_W'(HEADER_BYTES);

  always_comb begin
    sq_d     = sq_q;
    phase_d  = phase_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cursor_d = cursor_q;
    used_d   = used_q;
    left_d   = left_q;
    pkt_d    = pkt_q;
    len_d    = len_q;
    lo_d     = lo_q;
    op_d     = op_q;
    hk_d     = hk_q;
    out_load = 1'b0;
    o_status = ST_OK;
    o_rlen   = '0;
    o_rbyte  = '0;
    o_last   = 1'b0;
    we       = 1'b0;
    waddr    = tail_q;
    wdata    = '0;
    hdr_rd   = 1'b0;
    hdr_addr = head_q;

    unique case (sq_q)
      SQ_IDLE: begin
        if (in_fire) begin
          len_d = length_i;
          op_d  = op;
          unique case (op)
            OP_CLEAR: begin
              head_d   = '0;
              tail_d   = '0;
              used_d   = '0;
              phase_d  = PH_IDLE;
              cursor_d = '0;
              left_d   = '0;
              pkt_d    = '0;
              out_load = 1'b1;
            end
            OP_WR_BEGIN: begin
              if (phase_q != PH_IDLE) begin
                o_status = ST_SEQ;
                out_load = 1'b1;
              end else if (need > CMP_W'(free_now)) begin
                o_status = ST_NO_SPACE;
                o_rlen   = need - CMP_W'(free_now);
                out_load = 1'b1;
              end else begin
                we    = 1'b1;
                waddr = tail_q;
                wdata = length_i[7:0];
                hk_d  = HK_W'(1);
                sq_d  = SQ_WHDR;
              end
            end
            OP_WR_BYTE: begin
              out_load = 1'b1;
              if (phase_q != PH_WRITE) begin
                o_status = ST_SEQ;
              end else begin
                we       = 1'b1;
                waddr    = cursor_q;
                wdata    = data_byte_i;
                cursor_d = adv(cursor_q, CNT_W'(1));
                left_d   = left_q - 16'd1;
                o_rlen   = CMP_W'(pkt_q);
                if (left_q == 16'd1) begin
                  tail_d  = cursor_d;
                  used_d  = used_q + CNT_W'(HEADER_BYTES) + CNT_W'(pkt_q);
                  phase_d = PH_IDLE;
                  o_last  = 1'b1;
                end
              end
            end
            OP_RD_BEGIN: begin
              if (phase_q != PH_IDLE) begin
                o_status = ST_SEQ;
                out_load = 1'b1;
              end else if (used_q == '0) begin
                o_status = ST_EMPTY;
                out_load = 1'b1;
              end else begin
                hdr_rd   = 1'b1;
                hdr_addr = head_q;
                sq_d     = SQ_HDR_LO;
              end
            end
            OP_RD_BYTE: begin
              out_load = 1'b1;
              if (phase_q != PH_READ) begin
                o_status = ST_SEQ;
              end else begin
                o_rbyte  = rdata;
                cursor_d = adv(cursor_q, CNT_W'(1));
                left_d   = left_q - 16'd1;
                o_rlen   = CMP_W'(pkt_q);
                if (left_q == 16'd1) begin
                  head_d  = cursor_d;
                  phase_d = PH_IDLE;
                  o_last  = 1'b1;
                  if (CMP_W'(used_q) >= CMP_W'(pkt_q) + CMP_W'(HEADER_BYTES)) begin
                    used_d = used_q - CNT_W'(pkt_q) - CNT_W'(HEADER_BYTES);
                  end else begin
                    used_d = '0;
                  end
                end
              end
            end
            OP_RETAIN: begin
              if (phase_q != PH_IDLE) begin
                o_status = ST_SEQ;
                out_load = 1'b1;
              end else if (CMP_W'(length_i) > CMP_W'(RING_BYTES)) begin
                out_load = 1'b1;
              end else if (CMP_W'(free_now) < CMP_W'(length_i) && used_q != '0) begin
                hdr_rd   = 1'b1;
                hdr_addr = head_q;
                sq_d     = SQ_HDR_LO;
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              o_status = ST_SEQ;
              out_load = 1'b1;
            end
          endcase
        end
      end
      SQ_WHDR: begin
        we    = 1'b1;
        waddr = adv(tail_q, CNT_W'(hk_q));
        wdata = (hk_q == HK_W'(1)) ? len_q[15:8] : 8'd0;
        hk_d  = hk_q + HK_W'(1);
        if (hk_q == HK_W'(HEADER_BYTES - 1)) begin
          cursor_d = adv(tail_q, CNT_W'(HEADER_BYTES));
          left_d   = len_q;
          pkt_d    = len_q;
          o_rlen   = CMP_W'(len_q);
          out_load = 1'b1;
          sq_d     = SQ_IDLE;
          if (len_q == 16'd0) begin
            tail_d = cursor_d;
            used_d = used_q + CNT_W'(HEADER_BYTES);
          end else begin
            phase_d = PH_WRITE;
          end
        end
      end
      SQ_HDR_LO: begin
        lo_d     = rdata;
        hdr_rd   = 1'b1;
        hdr_addr = adv(head_q, CNT_W'(1));
        sq_d     = SQ_HDR_HI;
      end
      SQ_HDR_HI: begin
        if (op_q == OP_RD_BEGIN) begin
          out_load = 1'b1;
          sq_d     = SQ_IDLE;
          o_rlen   = CMP_W'(pk);
          if (len_q < pk) begin
            o_status = ST_TOO_SMALL;
          end else begin
            cursor_d = adv(head_q, CNT_W'(HEADER_BYTES));
            left_d   = pk;
            pkt_d    = pk;
            if (pk == 16'd0) begin
              head_d = cursor_d;
              used_d = (used_q >= CNT_W'(HEADER_BYTES)) ?
                       used_q - CNT_W'(HEADER_BYTES) : '0;
            end else begin
              phase_d = PH_READ;
            end
          end
        end else begin
          if (pk_total > CMP_W'(used_q)) begin
            head_d   = tail_q;
            used_d   = '0;
            out_load = 1'b1;
            sq_d     = SQ_IDLE;
          end else begin
            head_d = adv(head_q, CNT_W'(pk_total));
            used_d = used_q - CNT_W'(pk_total);
            if (CMP_W'(CNT_W'(RING_BYTES) - used_d) < CMP_W'(len_q) && used_d != '0) begin
              hdr_rd   = 1'b1;
              hdr_addr = head_d;
              sq_d     = SQ_HDR_LO;
            end else begin
              out_load = 1'b1;
              sq_d     = SQ_IDLE;
            end
          end
        end
      end
    endcase

    raddr       = hdr_rd ? hdr_addr : cursor_d;
    free_d      = CNT_W'(RING_BYTES) - used_d;
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q        <= SQ_IDLE;
      phase_q     <= PH_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cursor_q    <= '0;
      used_q      <= '0;
      left_q      <= '0;
      pkt_q       <= '0;
      hk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sq_q        <= sq_d;
      phase_q     <= phase_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cursor_q    <= cursor_d;
      used_q      <= used_d;
      left_q      <= left_d;
      pkt_q       <= pkt_d;
      hk_q        <= hk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    lo_q  <= lo_d;
    op_q  <= op_d;
    if (out_load) begin
      status_q <= o_status;
      rlen_q   <= o_rlen;
      rbyte_q  <= o_rbyte;
      last_q   <= o_last;
      free_q   <= free_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_length_o = rlen_q;
  assign read_byte_o     = rbyte_q;
  assign last_byte_o     = last_q;
  assign free_bytes_o    = 11'(free_q);

  `LPPR_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= CNT_W'(RING_BYTES), "used count over capacity")
  `LPPR_ASSERT(a_busy_slot_free, clk_i, rst_ni, sq_q == SQ_IDLE || !out_valid_q, "result slot busy during multi-cycle item")
  `LPPR_ASSERT(a_phase_left, clk_i, rst_ni, phase_q == PH_IDLE || left_q != 16'd0, "packet open with no bytes left")
  `LPPR_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, out_load, out_valid_q, "result beat lost")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Packet ring testbench
// Drives clear, packet write and read sequences, retain requests and
// out-of-sequence noise into the packet ring with random gaps on both
// channels. Each accepted beat is run through a local model of the ring,
// and every result beat is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;
  import lppr_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT  = 5000;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] len;
    logic [7:0]  data;
  } ring_item_t;

  typedef struct packed {
    status_e     status;
    logic [16:0] rlen;
    logic [7:0]  rbyte;
    logic        last;
    logic [10:0] free;
  } ring_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic [2:0]  opcode      = '0;
  logic [15:0] length      = '0;
  logic [7:0]  data_byte   = '0;
  logic        out_ready   = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [16:0] result_length_o;
  logic [7:0]  read_byte_o;
  logic        last_byte_o;
  logic [10:0] free_bytes_o;

  ring_item_t   pending_items[$];
  ring_result_t expected_results[$];
  int           items_total;
  int           items_accepted;
  int           results_seen;
  int           fail_count;
  int           send_gap;
  int           recv_gap;
  int           hold_cycles;
  logic         send_burst;
  logic         recv_burst;

  logic [7:0]         m_ring [RING_BYTES];
  logic [IDX_W-1:0]   m_head;
  logic [IDX_W-1:0]   m_tail;
  logic [IDX_W-1:0]   m_cursor;
  logic [CNT_W-1:0]   m_used;
  logic [15:0]        m_left;
  logic [15:0]        m_plen;
  phase_e             m_phase;

  length_prefixed_packet_ring DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode),
    .length_i        (length),
    .data_byte_i     (data_byte),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .status_o        (status_o),
    .result_length_o (result_length_o),
    .read_byte_o     (read_byte_o),
    .last_byte_o     (last_byte_o),
    .free_bytes_o    (free_bytes_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] idx, int n);
    return IDX_W'((int'(idx) + n) % RING_BYTES);
  endfunction

  function automatic ring_result_t predict_ring_result(logic [2:0] op, logic [15:0] len,
                                                       logic [7:0] data);
    ring_result_t r;
    int need;
    int room;
    int pk;
    int total;
    r = '{status: ST_OK, rlen: '0, rbyte: '0, last: 1'b0, free: '0};
    case (op)
      OP_CLEAR: begin
        m_head   = '0;
        m_tail   = '0;
        m_used   = '0;
        m_phase  = PH_IDLE;
        m_cursor = '0;
        m_left   = '0;
        m_plen   = '0;
      end
      OP_WR_BEGIN: begin
        if (m_phase != PH_IDLE) begin
          r.status = ST_SEQ;
        end else begin
          need = HEADER_BYTES + int'(len);
          room = RING_BYTES - int'(m_used);
          if (need > room) begin
            r.status = ST_NO_SPACE;
            r.rlen   = 17'(need - room);
          end else begin
            m_ring[m_tail]              = len[7:0];
            m_ring[ring_add(m_tail, 1)] = len[15:8];
            m_ring[ring_add(m_tail, 2)] = 8'h00;
            m_ring[ring_add(m_tail, 3)] = 8'h00;
            m_cursor = ring_add(m_tail, HEADER_BYTES);
            m_left   = len;
            m_plen   = len;
            r.rlen   = 17'(len);
            if (len == 0) begin
              m_tail = m_cursor;
              m_used = m_used + CNT_W'(HEADER_BYTES);
            end else begin
              m_phase = PH_WRITE;
            end
          end
        end
      end
      OP_WR_BYTE: begin
        if (m_phase != PH_WRITE) begin
          r.status = ST_SEQ;
        end else begin
          m_ring[m_cursor] = data;
          m_cursor = ring_add(m_cursor, 1);
          if (m_left > 0) m_left = m_left - 1'b1;
          r.rlen = 17'(m_plen);
          if (m_left == 0) begin
            m_tail  = m_cursor;
            m_used  = CNT_W'(int'(m_used) + HEADER_BYTES + int'(m_plen));
            m_phase = PH_IDLE;
            r.last  = 1'b1;
          end
        end
      end
      OP_RD_BEGIN: begin
        if (m_phase != PH_IDLE) begin
          r.status = ST_SEQ;
        end else if (m_used == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pk = int'({m_ring[ring_add(m_head, 1)], m_ring[m_head]});
          r.rlen = 17'(pk);
          if (int'(len) < pk) begin
            r.status = ST_TOO_SMALL;
          end else begin
            m_cursor = ring_add(m_head, HEADER_BYTES);
            m_left   = 16'(pk);
            m_plen   = 16'(pk);
            if (pk == 0) begin
              m_head = m_cursor;
              m_used = (m_used >= HEADER_BYTES) ? m_used - CNT_W'(HEADER_BYTES) : '0;
            end else begin
              m_phase = PH_READ;
            end
          end
        end
      end
      OP_RD_BYTE: begin
        if (m_phase != PH_READ) begin
          r.status = ST_SEQ;
        end else begin
          r.rbyte  = m_ring[m_cursor];
          m_cursor = ring_add(m_cursor, 1);
          if (m_left > 0) m_left = m_left - 1'b1;
          r.rlen = 17'(m_plen);
          if (m_left == 0) begin
            total   = HEADER_BYTES + int'(m_plen);
            m_head  = m_cursor;
            m_used  = (int'(m_used) >= total) ? CNT_W'(int'(m_used) - total) : '0;
            m_phase = PH_IDLE;
            r.last  = 1'b1;
          end
        end
      end
      OP_RETAIN: begin
        if (m_phase != PH_IDLE) begin
          r.status = ST_SEQ;
        end else if (int'(len) <= RING_BYTES) begin
          while (RING_BYTES - int'(m_used) < int'(len) && m_used > 0) begin
            total = HEADER_BYTES + int'({m_ring[ring_add(m_head, 1)], m_ring[m_head]});
            if (total > int'(m_used)) begin
              m_head = m_tail;
              m_used = '0;
              break;
            end
            m_head = ring_add(m_head, total);
            m_used = CNT_W'(int'(m_used) - total);
          end
        end
      end
      default: r.status = ST_SEQ;
    endcase
    r.free = 11'(RING_BYTES - int'(m_used));
    return r;
  endfunction

  function automatic int pick_gap(logic burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_item(logic [2:0] op, logic [15:0] len, logic [7:0] data);
    ring_item_t it;
    it.op   = op;
    it.len  = len;
    it.data = data;
    pending_items.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    ring_item_t nxt;
    logic       v_next;
    if (rst_ni) begin
      v_next = in_valid;
      if (in_valid && in_ready_o) begin
        expected_results.push_back(predict_ring_result(opcode, length, data_byte));
        items_accepted++;
        v_next = 1'b0;
        if ($urandom_range(0, 59) == 0) send_burst = ~send_burst;
        send_gap = pick_gap(send_burst);
      end
      if (!v_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          opcode    <= nxt.op;
          length    <= nxt.len;
          data_byte <= nxt.data;
          v_next = 1'b1;
        end
      end
      in_valid <= v_next;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ring_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result without expectation", status_o, 0);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (result_length_o !== want.rlen)
            report_mismatch("result_length", result_length_o, want.rlen);
          if (read_byte_o !== want.rbyte) report_mismatch("read_byte", read_byte_o, want.rbyte);
          if (last_byte_o !== want.last) report_mismatch("last_byte", last_byte_o, want.last);
          if (free_bytes_o !== want.free)
            report_mismatch("free_bytes", free_bytes_o, want.free);
        end
        if ($urandom_range(0, 59) == 0) recv_burst = ~recv_burst;
        recv_gap = pick_gap(recv_burst);
        if (results_seen == 250) hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    logic [2:0] wr_noise [6];
    logic [2:0] rd_noise [6];
    logic [2:0] idle_noise [4];
    int         gen_pkts[$];
    int         gen_used;
    int         ignored;
    int         pick;
    int         sel;
    int         room;
    int         plen;
    int         cap;
    int         k;
    logic       aborted;

    wr_noise   = '{OP_WR_BEGIN, OP_RD_BEGIN, OP_RD_BYTE, OP_RETAIN, 3'd6, 3'd7};
    rd_noise   = '{OP_WR_BEGIN, OP_RD_BEGIN, OP_WR_BYTE, OP_RETAIN, 3'd6, 3'd7};
    idle_noise = '{OP_WR_BYTE, OP_RD_BYTE, 3'd6, 3'd7};
    m_head = '0; m_tail = '0; m_cursor = '0; m_used = '0;
    m_left = '0; m_plen = '0; m_phase = PH_IDLE;
    for (k = 0; k < RING_BYTES; k++) m_ring[k] = 8'h00;
    send_gap = 0; recv_gap = 0; hold_cycles = 0;
    send_burst = 1'b0; recv_burst = 1'b0;
    items_accepted = 0; results_seen = 0; fail_count = 0;

    add_item(OP_RD_BEGIN, 16'd0, 8'h00);
    add_item(OP_RD_BYTE, 16'hFFFF, 8'hFF);
    add_item(OP_WR_BYTE, 16'h0000, 8'h5A);
    add_item(3'd6, 16'h1234, 8'h00);
    add_item(3'd7, 16'hFFFF, 8'hFF);
    add_item(OP_WR_BEGIN, 16'hFFFF, 8'h00);
    add_item(OP_WR_BEGIN, 16'd0, 8'h00);
    add_item(OP_WR_BEGIN, 16'd2, 8'h00);
    add_item(OP_WR_BYTE, 16'd0, 8'h00);
    add_item(OP_WR_BYTE, 16'd0, 8'hFF);
    add_item(OP_RD_BEGIN, 16'd0, 8'h00);
    add_item(OP_RD_BEGIN, 16'd1, 8'h00);
    add_item(OP_RD_BEGIN, 16'hFFFF, 8'h00);
    add_item(OP_RD_BYTE, 16'd0, 8'h00);
    add_item(OP_RD_BYTE, 16'd0, 8'h00);
    add_item(OP_RETAIN, 16'd2000, 8'h00);
    add_item(OP_WR_BEGIN, 16'd1021, 8'h00);
    add_item(OP_WR_BEGIN, 16'd3, 8'h00);
    add_item(OP_WR_BYTE, 16'd0, 8'h81);
    add_item(OP_WR_BYTE, 16'd0, 8'h7E);
    add_item(OP_WR_BYTE, 16'd0, 8'hC3);
    add_item(OP_RETAIN, 16'd1024, 8'h00);
    add_item(OP_WR_BEGIN, 16'd5, 8'h00);
    add_item(OP_WR_BYTE, 16'd0, 8'hA5);
    add_item(OP_CLEAR, 16'hFFFF, 8'hFF);

    k = pending_items.size();
    gen_used = 0;
    ignored = 0;
    while (pending_items.size() - ignored - k < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        room = RING_BYTES - gen_used;
        sel  = $urandom_range(0, 99);
        if (sel < 70) plen = $urandom_range(0, 12);
        else if (sel < 92) plen = $urandom_range(13, 80);
        else if (sel < 94 && room > HEADER_BYTES) plen = $urandom_range(0, room - HEADER_BYTES);
        else plen = $urandom_range(0, 65535);
        add_item(OP_WR_BEGIN, 16'(plen), 8'($urandom()));
        if (plen + HEADER_BYTES <= room) begin
          aborted = 1'b0;
          for (int b = 0; b < plen && !aborted; b++) begin
            if ($urandom_range(0, 29) == 0) begin
              add_item(wr_noise[$urandom_range(0, 5)], 16'($urandom()), 8'($urandom()));
              ignored++;
            end
            if ($urandom_range(0, 199) == 0) begin
              add_item(OP_CLEAR, 16'($urandom()), 8'($urandom()));
              gen_pkts.delete();
              gen_used = 0;
              aborted = 1'b1;
            end else begin
              add_item(OP_WR_BYTE, 16'($urandom()), 8'($urandom()));
            end
          end
          if (!aborted) begin
            gen_pkts.push_back(plen);
            gen_used += plen + HEADER_BYTES;
          end
        end
      end else if (pick < 72) begin
        if (gen_pkts.size() == 0) begin
          add_item(OP_RD_BEGIN, 16'($urandom()), 8'($urandom()));
        end else begin
          plen = gen_pkts[0];
          if (plen > 0 && $urandom_range(0, 99) < 15) cap = $urandom_range(0, plen - 1);
          else cap = $urandom_range(plen, 65535);
          add_item(OP_RD_BEGIN, 16'(cap), 8'($urandom()));
          if (cap >= plen) begin
            aborted = 1'b0;
            for (int b = 0; b < plen && !aborted; b++) begin
              if ($urandom_range(0, 29) == 0) begin
                add_item(rd_noise[$urandom_range(0, 5)], 16'($urandom()), 8'($urandom()));
                ignored++;
              end
              if ($urandom_range(0, 199) == 0) begin
                add_item(OP_CLEAR, 16'($urandom()), 8'($urandom()));
                gen_pkts.delete();
                gen_used = 0;
                aborted = 1'b1;
              end else begin
                add_item(OP_RD_BYTE, 16'($urandom()), 8'($urandom()));
              end
            end
            if (!aborted) begin
              void'(gen_pkts.pop_front());
              gen_used -= plen + HEADER_BYTES;
            end
          end
        end
      end else if (pick < 82) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) cap = $urandom_range(RING_BYTES + 1, 65535);
        else if (sel < 20) cap = RING_BYTES;
        else cap = $urandom_range(0, RING_BYTES);
        add_item(OP_RETAIN, 16'(cap), 8'($urandom()));
        if (cap <= RING_BYTES) begin
          while (RING_BYTES - gen_used < cap && gen_pkts.size() > 0) begin
            gen_used -= gen_pkts.pop_front() + HEADER_BYTES;
          end
        end
      end else if (pick < 85) begin
        add_item(OP_CLEAR, 16'($urandom()), 8'($urandom()));
        gen_pkts.delete();
        gen_used = 0;
      end else begin
        add_item(idle_noise[$urandom_range(0, 3)], 16'($urandom()), 8'($urandom()));
        ignored++;
      end
    end
    items_total = pending_items.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (items_accepted < items_total || expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
